@@ rtl/scan_polar_to_grid_projector_macros.svh @@
// Assertion macros shared by the scan projector RTL.
`ifndef SCAN_POLAR_TO_GRID_PROJECTOR_MACROS_SVH
`define SCAN_POLAR_TO_GRID_PROJECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SP2G_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sp2g assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SP2G_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sp2g assertion failed");

`endif

@@ rtl/sp2g_pkg.sv @@
// Shared types, constants and tables of the scan projector.
`default_nettype none
package sp2g_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [15:0] MAX_RANGE_RESET = 16'd10000;

    typedef enum logic [1:0] {
        CFG_ANGLE_START = 2'd0,
        CFG_ANGLE_STEP  = 2'd1,
        CFG_MAX_RANGE   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] angle;
        logic [15:0] range;
        logic [15:0] maxr;
        logic        use_pt;
        logic        off_pre;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
    } t_fifo_stat;

    // Arctangent of 2^-i in 2^-32 turn units.
    function automatic logic signed [CW-1:0] atan_turn(input logic [3:0] idx);
        case (idx)
            4'd0:    return 34'sd536870912;
            4'd1:    return 34'sd316933406;
            4'd2:    return 34'sd167458907;
            4'd3:    return 34'sd85004756;
            4'd4:    return 34'sd42667331;
            4'd5:    return 34'sd21354465;
            4'd6:    return 34'sd10680350;
            4'd7:    return 34'sd5340245;
            4'd8:    return 34'sd2670675;
            4'd9:    return 34'sd1335343;
            4'd10:   return 34'sd667544;
            4'd11:   return 34'sd333772;
            4'd12:   return 34'sd166886;
            4'd13:   return 34'sd83443;
            4'd14:   return 34'sd41721;
            4'd15:   return 34'sd20860;
            default: return '0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ rtl/sp2g_front.sv @@
// Front end: configuration registers, sample acceptance, angle and classification.
`default_nettype none
module sp2g_front #(
    parameter int BEAM_COUNT = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [15:0]           i_range_mm,
    input  wire logic                  i_range_valid,
    input  wire logic [11:0]           i_beam_index,
    input  wire logic                  i_last_beam,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [31:0]           i_cfg_data,
    input  wire sp2g_pkg::t_fifo_stat  i_fifo_stat,
    output logic                       o_push,
    output sp2g_pkg::t_item            o_item
);

    logic [31:0] r_start, r_step;
    logic [15:0] r_max;
    logic        r_vld;
    logic [15:0] r_range;
    logic        r_valid;
    logic [11:0] r_beam;
    logic        r_last;

    logic        accept;
    logic [15:0] maxr;
    logic        beam_ok;
    logic [3:0]  fill;

    assign o_cfg_ready = 1'b1;
    assign fill    = {1'b0, i_fifo_stat.count} + {3'b0, r_vld};
    assign busy    = (fill >= 4'(sp2g_pkg::FIFO_DEPTH));
    assign accept  = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_step  <= '0;
            r_max   <= sp2g_pkg::MAX_RANGE_RESET;
        end else if (i_cfg_valid) begin
            case (sp2g_pkg::t_cfg_idx'(i_cfg_index))
                sp2g_pkg::CFG_ANGLE_START: r_start <= i_cfg_data;
                sp2g_pkg::CFG_ANGLE_STEP:  r_step  <= i_cfg_data;
                sp2g_pkg::CFG_MAX_RANGE:   r_max   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_range <= i_range_mm;
            r_valid <= i_range_valid;
            r_beam  <= i_beam_index;
            r_last  <= i_last_beam;
        end
    end

    assign maxr    = (r_max == 16'd0) ? 16'd1 : r_max;
    assign beam_ok = (32'(r_beam) < BEAM_COUNT);

    always_comb begin
        o_push         = r_vld;
        o_item.angle   = r_start + ({20'b0, r_beam} * r_step);
        o_item.range   = r_range;
        o_item.maxr    = maxr;
        o_item.use_pt  = r_valid && beam_ok && (r_range <= maxr);
        o_item.off_pre = r_valid && beam_ok && (r_range > maxr);
        o_item.last    = r_last;
    end

endmodule
`default_nettype wire

@@ rtl/sp2g_fifo.sv @@
// Short queue between the front end and the projection pipeline.
`default_nettype none
`include "scan_polar_to_grid_projector_macros.svh"
module sp2g_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire sp2g_pkg::t_item       i_item,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output sp2g_pkg::t_item            o_item,
    output sp2g_pkg::t_fifo_stat       o_stat
);

    sp2g_pkg::t_item                   r_mem [sp2g_pkg::FIFO_DEPTH];
    logic [sp2g_pkg::FIFO_AW-1:0]      r_wr, r_rd;
    logic [sp2g_pkg::FIFO_CW-1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    assign o_valid      = (r_count != '0);
    assign o_item       = r_mem[r_rd];
    assign o_stat.count = r_count;

    `SP2G_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push, (r_count != 3'(sp2g_pkg::FIFO_DEPTH)) || i_pop)
    `SP2G_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `SP2G_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 3'd1)

endmodule
`default_nettype wire

@@ rtl/sp2g_back.sv @@
// Back end: CORDIC, projection multiply and pipelined divide to pixel coordinates.
`default_nettype none
module sp2g_back #(
    parameter int GRID_SIZE = 512
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire sp2g_pkg::t_item  i_item,
    output logic                  o_pop,
    output logic                  o_strobe,
    output logic [8:0]            o_pixel_x,
    output logic [8:0]            o_pixel_y,
    output logic                  o_hit,
    output logic                  o_off_grid,
    output logic                  o_last_point
);

    localparam int N    = sp2g_pkg::CORDIC_STEPS;
    localparam int CW   = sp2g_pkg::CW;
    localparam int HALF = GRID_SIZE / 2;
    localparam int HW   = $clog2(HALF + 1);
    localparam int NW   = CW + 17;
    localparam int DW   = NW + HW - 30;
    localparam int QB   = $clog2(GRID_SIZE) + 1;

    // CORDIC stages.
    logic signed [CW-1:0] r_x [N+1];
    logic signed [CW-1:0] r_y [N+1];
    logic signed [CW-1:0] r_z [N+1];
    logic [1:0]           r_q [N+1];
    sp2g_pkg::t_item      r_sc [N+1];
    logic                 r_vc [N+1];

    logic [31:0] fold_sum, fold_res;

    assign o_pop    = i_valid;
    assign fold_sum = i_item.angle + 32'h2000_0000;
    assign fold_res = i_item.angle - {fold_sum[31:30], 30'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc[0] <= 1'b0;
        else          r_vc[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_x[0]  <= sp2g_pkg::CORDIC_GAIN;
        r_y[0]  <= '0;
        r_z[0]  <= {{(CW-32){fold_res[31]}}, fold_res};
        r_q[0]  <= fold_sum[31:30];
        r_sc[0] <= i_item;
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [CW-1:0] dx, dy, da;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign da = sp2g_pkg::atan_turn(4'(i));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vc[i+1] <= 1'b0;
            else          r_vc[i+1] <= r_vc[i];
        end

        always_ff @(posedge i_clk) begin
            if (!r_z[i][CW-1]) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - da;
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + da;
            end
            r_q[i+1]  <= r_q[i];
            r_sc[i+1] <= r_sc[i];
        end
    end

    // Quadrant rotation.
    logic signed [CW-1:0] r_c, r_s;
    sp2g_pkg::t_item      r_sr;
    logic                 r_vr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vr <= 1'b0;
        else          r_vr <= r_vc[N];
    end

    always_ff @(posedge i_clk) begin
        case (r_q[N])
            2'd0:    begin r_c <= r_x[N];  r_s <= r_y[N];  end
            2'd1:    begin r_c <= -r_y[N]; r_s <= r_x[N];  end
            2'd2:    begin r_c <= -r_x[N]; r_s <= -r_y[N]; end
            default: begin r_c <= r_y[N];  r_s <= -r_x[N]; end
        endcase
        r_sr <= r_sc[N];
    end

    // Range times trig.
    logic signed [NW-1:0] r_nx, r_ny;
    sp2g_pkg::t_item      r_sm;
    logic                 r_vm;
    logic signed [16:0]   range_s;

    assign range_s = $signed({1'b0, r_sr.range});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vm <= 1'b0;
        else          r_vm <= r_vr;
    end

    always_ff @(posedge i_clk) begin
        r_nx <= NW'(range_s * r_c);
        r_ny <= NW'(range_s * r_s);
        r_sm <= r_sr;
    end

    // Add the grid center term: numerator over the scale is half times this sum.
    logic signed [NW-1:0] r_ux, r_uy;
    sp2g_pkg::t_item      r_su;
    logic                 r_vu;
    logic signed [NW-1:0] center;

    assign center = $signed(NW'({r_sm.maxr, 30'b0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vu <= 1'b0;
        else          r_vu <= r_vm;
    end

    always_ff @(posedge i_clk) begin
        r_ux <= r_nx + center;
        r_uy <= r_ny + center;
        r_su <= r_sm;
    end

    // Restoring divide by the maximum range, one quotient bit per stage.
    logic [DW-1:0]   r_rx [QB+1];
    logic [DW-1:0]   r_ry [QB+1];
    logic [QB-1:0]   r_qx [QB+1];
    logic [QB-1:0]   r_qy [QB+1];
    logic            r_gx [QB+1];
    logic            r_gy [QB+1];
    sp2g_pkg::t_item r_sv [QB+1];
    logic            r_vv [QB+1];

    // Magnitude, scale by half the grid, drop the 2^30 part of the divisor.
    // The result loads the first divider stage.
    logic [NW-1:0]    ax, ay;
    logic [NW+HW-1:0] mx, my;

    assign ax = r_ux[NW-1] ? NW'(-r_ux) : NW'(r_ux);
    assign ay = r_uy[NW-1] ? NW'(-r_uy) : NW'(r_uy);
    assign mx = ax * HW'(HALF);
    assign my = ay * HW'(HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vv[0] <= 1'b0;
        else          r_vv[0] <= r_vu;
    end

    always_ff @(posedge i_clk) begin
        r_rx[0] <= mx[NW+HW-1:30];
        r_ry[0] <= my[NW+HW-1:30];
        r_qx[0] <= '0;
        r_qy[0] <= '0;
        r_gx[0] <= r_ux[NW-1];
        r_gy[0] <= r_uy[NW-1];
        r_sv[0] <= r_su;
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [DW-1:0] sub;
        logic          bx, by;
        assign sub = DW'(r_sv[j].maxr) << (QB - 1 - j);
        assign bx  = (r_rx[j] >= sub);
        assign by  = (r_ry[j] >= sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vv[j+1] <= 1'b0;
            else          r_vv[j+1] <= r_vv[j];
        end

        always_ff @(posedge i_clk) begin
            r_rx[j+1] <= bx ? r_rx[j] - sub : r_rx[j];
            r_ry[j+1] <= by ? r_ry[j] - sub : r_ry[j];
            r_qx[j+1] <= {r_qx[j][QB-2:0], bx};
            r_qy[j+1] <= {r_qy[j][QB-2:0], by};
            r_gx[j+1] <= r_gx[j];
            r_gy[j+1] <= r_gy[j];
            r_sv[j+1] <= r_sv[j];
        end
    end

    // Grid check and result register.
    logic [QB-1:0]   qx, qy;
    logic            out_x, out_y, outside, hit;
    sp2g_pkg::t_item sf;

    assign qx      = r_qx[QB];
    assign qy      = r_qy[QB];
    assign sf      = r_sv[QB];
    // A small negative numerator truncates to column zero, which is on the grid.
    assign out_x   = (r_gx[QB] && (qx != '0)) || (qx >= QB'(GRID_SIZE));
    assign out_y   = (r_gy[QB] && (qy != '0)) || (qy >= QB'(GRID_SIZE));
    assign outside = out_x || out_y;
    assign hit     = sf.use_pt && !outside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe   <= 1'b0;
            o_hit      <= 1'b0;
            o_off_grid <= 1'b0;
        end else begin
            o_strobe   <= r_vv[QB];
            o_hit      <= r_vv[QB] && hit;
            o_off_grid <= r_vv[QB] && (sf.off_pre || (sf.use_pt && outside));
        end
    end

    always_ff @(posedge i_clk) begin
        o_pixel_x    <= (r_vv[QB] && hit) ? 9'(qx) : 9'd0;
        o_pixel_y    <= (r_vv[QB] && hit) ? 9'(qy) : 9'd0;
        o_last_point <= r_vv[QB] && sf.last;
    end

endmodule
`default_nettype wire

@@ rtl/scan_polar_to_grid_projector.sv @@
// Top level of the lidar scan polar-to-grid projector.
`default_nettype none
`include "scan_polar_to_grid_projector_macros.svh"
// One range sample is accepted per clock at an edge with start high and busy low, and
// its result appears on the o_ ports for exactly one cycle with o_strobe high, in
// input order; the receiver cannot stall, so read each result in the cycle it shows.
// On its way to o_strobe a sample passes the front-end register, the queue, the
// CORDIC input register and its 16 stages, a rotate, multiply, offset and scale
// stage, a restoring divider with one stage per quotient bit, and the result
// register. The sustained rate is one sample per cycle;
// the pipeline never waits, so busy only rises if the short queue fills, which does
// not happen in normal streaming. The beam angle is angle_start plus beam_index times
// angle_step in 2^-32 turn units, wrapping at one turn. Invalid samples and beams at
// or past BEAM_COUNT give all-zero results; ranges past max_range_mm and points that
// fall outside the grid set off_grid and clear hit. A max_range_mm of zero acts as one.
// Configuration writes are taken every cycle (cfg ready is always high) and must only
// happen while no sample is in flight; there is no clearing pass after reset.
module scan_polar_to_grid_projector #(
    parameter int GRID_SIZE  = 512,
    parameter int BEAM_COUNT = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_range_mm,
    input  wire logic        i_range_valid,
    input  wire logic [11:0] i_beam_index,
    input  wire logic        i_last_beam,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_strobe,
    output logic [8:0]       o_pixel_x,
    output logic [8:0]       o_pixel_y,
    output logic             o_hit,
    output logic             o_off_grid,
    output logic             o_last_point
);

    // Beats between the front end, the queue and the projection pipeline.
    sp2g_pkg::t_item      front_item, queue_item;
    sp2g_pkg::t_fifo_stat fifo_stat;
    logic                 push, queue_valid, pop;

    // The front end holds the registers, accepts a beat and classifies it.
    sp2g_front #(
        .BEAM_COUNT (BEAM_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_range_mm    (i_range_mm),
        .i_range_valid (i_range_valid),
        .i_beam_index  (i_beam_index),
        .i_last_beam   (i_last_beam),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_fifo_stat   (fifo_stat),
        .o_push        (push),
        .o_item        (front_item)
    );

    // The queue decouples acceptance from the pipeline.
    sp2g_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .o_stat  (fifo_stat)
    );

    // The back end computes trig, projects and divides, one beat per cycle.
    sp2g_back #(
        .GRID_SIZE (GRID_SIZE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .i_item       (queue_item),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_hit        (o_hit),
        .o_off_grid   (o_off_grid),
        .o_last_point (o_last_point)
    );

    // A point is either marked or reported off the grid, never both.
    `SP2G_ASSERT(a_hit_xor_off, i_clk, i_rst_n, o_strobe, !(o_hit && o_off_grid))
    // A marked pixel always lies inside the grid.
    `SP2G_ASSERT(a_hit_in_grid, i_clk, i_rst_n, o_hit, (32'(o_pixel_x) < GRID_SIZE) && (32'(o_pixel_y) < GRID_SIZE))
    // Flags stay low between results.
    `SP2G_ASSERT(a_idle_quiet, i_clk, i_rst_n, !o_strobe, !o_hit && !o_off_grid)

endmodule
`default_nettype wire

@@ dv/tb_scan_polar_to_grid_projector.sv @@
// Self-checking testbench for the lidar scan polar-to-grid projector.
`default_nettype none
module tb_scan_polar_to_grid_projector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID        = 512;
    localparam int HALF_GRID   = GRID / 2;
    // Extra drain wait, longer than the path from acceptance to strobe.
    localparam int DRAIN_CYCLES = 45;
    localparam int CYCLE_LIMIT  = 300000;
    // Index 3 is not a register; a write there must change nothing.
    localparam logic [1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic [8:0] px;
        logic [8:0] py;
        logic       hit;
        logic       off;
        logic       last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_range_mm = '0;
    logic        i_range_valid = 1'b0;
    logic [11:0] i_beam_index = '0;
    logic        i_last_beam = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_strobe;
    logic [8:0]  o_pixel_x;
    logic [8:0]  o_pixel_y;
    logic        o_hit;
    logic        o_off_grid;
    logic        o_last_point;

    // Predictor copy of the configuration registers.
    logic [31:0] cur_angle_start = '0;
    logic [31:0] cur_angle_step  = '0;
    logic [15:0] cur_max_range   = sp2g_pkg::MAX_RANGE_RESET;

    t_point      pending_points[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;

    always #10 i_clk = ~i_clk;

    scan_polar_to_grid_projector u_dut (.*);

    // Arctangent table of the CORDIC, 2^-32 turn units.
    const longint atan_tab[16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680350, 5340245, 2670675, 1335343, 667544, 333772,
        166886, 83443, 41721, 20860
    };

    // Scales range*trig into a grid coordinate, truncating toward zero.
    function automatic longint grid_coord(longint range, longint trig, longint maxr);
        longint den;
        den = maxr * (64'sd1 << 30);
        return (range * trig * HALF_GRID + HALF_GRID * den) / den;
    endfunction

    // Computes the pixel that one range sample projects to under the current setup.
    function automatic t_point project_sample(logic [15:0] range, logic valid,
                                              logic [11:0] beam, logic last);
        t_point      p;
        logic [31:0] ang, res;
        logic [1:0]  quad;
        longint      x, y, z, dx, dy, c, s, maxr, gx, gy;
        p = '0;
        p.last = last;
        maxr = (cur_max_range == 0) ? 1 : cur_max_range;
        if (!valid) return p;
        if (range > maxr) begin
            p.off = 1'b1;
            return p;
        end
        ang  = cur_angle_start + 32'(beam) * cur_angle_step;
        quad = 2'((ang + 32'h2000_0000) >> 30);
        res  = ang - {quad, 30'd0};
        z    = longint'(signed'(res));
        x    = 652032874;
        y    = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        gx = grid_coord(longint'(range), c, maxr);
        gy = grid_coord(longint'(range), s, maxr);
        if (gx < 0 || gx >= GRID || gy < 0 || gy >= GRID) begin
            p.off = 1'b1;
        end else begin
            p.px  = gx[8:0];
            p.py  = gy[8:0];
            p.hit = 1'b1;
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Every strobed result is checked against the oldest predicted point.
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_strobe) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected result, queue size", 1, 0);
            end else begin
                want = pending_points.pop_front();
                if (o_pixel_x != want.px) report_mismatch("pixel_x", o_pixel_x, want.px);
                if (o_pixel_y != want.py) report_mismatch("pixel_y", o_pixel_y, want.py);
                if (o_hit != want.hit) report_mismatch("hit", o_hit, want.hit);
                if (o_off_grid != want.off) report_mismatch("off_grid", o_off_grid, want.off);
                if (o_last_point != want.last)
                    report_mismatch("last_point", o_last_point, want.last);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Sends one sample beat; start stays high on return so back-to-back beats need
    // no extra assignment. Random idle cycles come first, at the phase's rate.
    task automatic send_sample(logic [15:0] range, logic valid, logic [11:0] beam,
                               logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_range_mm    <= range;
        i_range_valid <= valid;
        i_beam_index  <= beam;
        i_last_beam   <= last;
        do @(posedge i_clk); while (busy);
        pending_points = {pending_points, project_sample(range, valid, beam, last)};
    endtask

    // Stops sending and waits until the pipeline is empty.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write beat; the predictor copy follows the same decode. The valid
    // stays high on return so writes can follow back to back; the caller drops it.
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sp2g_pkg::CFG_ANGLE_START: cur_angle_start = data;
            sp2g_pkg::CFG_ANGLE_STEP:  cur_angle_step  = data;
            sp2g_pkg::CFG_MAX_RANGE:   cur_max_range   = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_scan(logic [31:0] a0, logic [31:0] step, logic [15:0] maxr);
        drain_pipeline();
        write_reg(sp2g_pkg::CFG_ANGLE_START, a0);
        write_reg(sp2g_pkg::CFG_ANGLE_STEP, step);
        write_reg(sp2g_pkg::CFG_MAX_RANGE, {16'd0, maxr});
        i_cfg_valid <= 1'b0;
    endtask

    // Extremes of every field, the reset setup, invalid samples, ranges at and past
    // the maximum, quadrant boundaries and a zero maximum that acts as one.
    task automatic test_directed();
        sender_idle_pct = 0;
        send_sample(16'd5000, 1'b1, 12'd0, 1'b0);
        send_sample(16'd10000, 1'b1, 12'd4095, 1'b1);
        send_sample(16'd10001, 1'b1, 12'd7, 1'b0);
        send_sample(16'hFFFF, 1'b0, 12'hFFF, 1'b1);
        send_sample(16'd0, 1'b1, 12'd0, 1'b0);
        set_scan(32'hE000_0000, 32'h4000_0000, 16'd1000);
        for (int b = 0; b < 4; b++) send_sample(16'd1000, 1'b1, 12'(b), b == 3);
        send_sample(16'd999, 1'b1, 12'd2, 1'b0);
        set_scan(32'h2000_0000, 32'hFFFF_FFFF, 16'd0);
        send_sample(16'd1, 1'b1, 12'd0, 1'b0);
        send_sample(16'd0, 1'b1, 12'd4095, 1'b0);
        send_sample(16'd2, 1'b1, 12'd1, 1'b1);
        set_scan(32'hFFFF_FFFF, 32'h0010_0000, 16'hFFFF);
        send_sample(16'hFFFF, 1'b1, 12'd0, 1'b0);
        send_sample(16'hFFFF, 1'b1, 12'd2048, 1'b0);
        send_sample(16'h8000, 1'b1, 12'd1024, 1'b1);
        // A write to an index past the register list must be ignored.
        drain_pipeline();
        write_reg(CFG_IDX_SPARE, 32'h0000_0001);
        i_cfg_valid <= 1'b0;
        send_sample(16'h7FFF, 1'b1, 12'd3072, 1'b0);
        send_sample(16'hFFFF, 1'b0, 12'd5, 1'b0);
    endtask

    // Random scans: mostly valid in-range samples with random content, some over
    // range, some invalid. Runs under the current sender idle rate.
    task automatic test_random_scans(int n_items);
        logic [15:0] maxr, range;
        int          sel;
        for (int k = 0; k < n_items; k++) begin
            if (k % 80 == 0) begin
                sel = $urandom_range(5);
                maxr = (sel == 0) ? 16'hFFFF : (sel == 1) ? 16'd1 :
                       (sel == 2) ? 16'(($urandom_range(200))) : 16'($urandom);
                set_scan($urandom, ($urandom_range(1)) ? $urandom : 32'($urandom_range(1 << 22)),
                         maxr);
            end
            maxr = (cur_max_range == 0) ? 16'd1 : cur_max_range;
            sel = $urandom_range(9);
            range = (sel < 7) ? 16'($urandom_range(maxr)) : 16'($urandom);
            send_sample(range, sel != 9, 12'($urandom), ($urandom_range(15) == 0));
        end
    endtask

    // Pauses the sender until every outstanding point has come back, then resumes.
    task automatic test_pause_to_empty();
        sender_idle_pct = 0;
        for (int k = 0; k < 10; k++) send_sample(16'($urandom), 1'b1, 12'($urandom), 1'b0);
        start <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        for (int k = 0; k < 10; k++) send_sample(16'($urandom), 1'b1, 12'($urandom), k == 9);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        sender_idle_pct = 0;
        test_random_scans(160);
        sender_idle_pct = 46;
        test_random_scans(160);
        test_pause_to_empty();
        sender_idle_pct = 0;
        test_random_scans(140);
        sender_idle_pct = 35;
        test_random_scans(150);
        drain_pipeline();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
